@@ rtl/vcv_pkg.sv @@
// Shared constants, types and tables for the view cone visibility test.
package vcv_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 20;

  // Angle word: enough for 270 degrees with FRAC_BITS fraction bits, plus sign.
  localparam int ANG_W  = FRAC_BITS + 11;
  // CORDIC datapath: 32-bit magnitudes scaled by 2^24, growth and sign.
  localparam int CRD_W  = 60;
  // Depth of the front-to-back queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [30:0] SD_RESET  = 31'd6553600;
  localparam logic [15:0] FOV_RESET = 16'd11520;

  // Configuration register indexes.
  localparam logic [0:0] REG_SIGHT_DISTANCE = 1'b0;
  localparam logic [0:0] REG_FOV_DEGREES    = 1'b1;

  // Reason codes.
  localparam logic [1:0] RSN_OUT_OF_RANGE = 2'd0;
  localparam logic [1:0] RSN_OVERLAP      = 2'd1;
  localparam logic [1:0] RSN_IN_CONE      = 2'd2;
  localparam logic [1:0] RSN_OUT_CONE     = 2'd3;

  typedef struct packed {
    logic signed [31:0] obs_x;
    logic signed [31:0] obs_y;
    logic signed [31:0] obs_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
    logic [30:0]        obs_radius;
    logic [30:0]        tgt_radius;
  } vcv_in_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] reason;
  } vcv_out_t;

  // Item handed from front to back: either decided, or a pending cone test.
  typedef struct packed {
    logic                     decided;
    vcv_out_t                 res;
    logic                     look_zero;
    logic signed [15:0]       l0, l1, l2;
    logic signed [15:0]       d0, d1, d2;
  } vcv_task_t;

  // CORDIC step angles in degrees, FRAC_BITS fraction bits, rounded.
  function automatic logic signed [ANG_W-1:0] step_angle(input int i);
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] r32;
    logic [63:0] p;
    int          k;
    int          e;
    int          sh;
    s  = 64'd0;
    k  = 0;
    e  = i;
    sh = 56 - FRAC_BITS;
    if (i == 0) begin
      return ANG_W'(45 <<< FRAC_BITS);
    end
    while (e <= 60) begin
      t = (64'd1 << (60 - e)) / 64'(2 * k + 1);
      if (k % 2 == 1) s = s - t;
      else s = s + t;
      k = k + 1;
      e = e + 2 * i;
    end
    r32 = (s + (64'd1 << 27)) >> 28;
    p   = r32 * 64'd961263669;
    return ANG_W'((p + (64'd1 << (sh - 1))) >> sh);
  endfunction

endpackage

@@ rtl/vcv_if.sv @@
// Valid/ready channel interfaces for input, result and configuration.
interface vcv_in_if (input logic clk);
  logic             valid;
  logic             ready;
  vcv_pkg::vcv_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcv_out_if (input logic clk);
  logic              valid;
  logic              ready;
  vcv_pkg::vcv_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcv_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/vcv_front.sv @@
// Front part: distance tests and vector reduction, pipelined, stall-by-enable.
module vcv_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [30:0]            sight_distance,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vcv_pkg::vcv_in_t       in_data,
  output logic                   t_valid,
  input  logic                   t_ready,
  output vcv_pkg::vcv_task_t     t_data
);

  // Stage valids; the whole pipe advances when the end can drain.
  logic [2:0] v_r;
  logic       adv;
  assign adv      = !v_r[2] || t_ready;
  assign in_ready = adv;
  assign t_valid  = v_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  // Stage 1: differences, magnitudes, reach.
  logic signed [32:0] dir_nxt [3];
  logic signed [32:0] dir_r   [3];
  logic [32:0]        mag_r   [3];
  logic signed [31:0] look_r  [3];
  logic [31:0]        lmag_r  [3];
  logic [31:0]        reach_r;
  logic [30:0]        orad_r;

  always_comb begin
    dir_nxt[0] = 33'(in_data.tgt_x) - 33'(in_data.obs_x);
    dir_nxt[1] = 33'(in_data.tgt_y) - 33'(in_data.obs_y);
    dir_nxt[2] = 33'(in_data.tgt_z) - 33'(in_data.obs_z);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        dir_r[j] <= dir_nxt[j];
        mag_r[j] <= dir_nxt[j][32] ? 33'(-dir_nxt[j]) : 33'(dir_nxt[j]);
      end
      look_r[0] <= in_data.look_x;
      look_r[1] <= in_data.look_y;
      look_r[2] <= in_data.look_z;
      lmag_r[0] <= in_data.look_x[31] ? 32'(-in_data.look_x) : 32'(in_data.look_x);
      lmag_r[1] <= in_data.look_y[31] ? 32'(-in_data.look_y) : 32'(in_data.look_y);
      lmag_r[2] <= in_data.look_z[31] ? 32'(-in_data.look_z) : 32'(in_data.look_z);
      reach_r   <= 32'(sight_distance) + 32'(in_data.tgt_radius);
      orad_r    <= in_data.obs_radius;
    end
  end

  // Stage 2: squares (each about 33x33), shift counts for reduction.
  logic [65:0] sq_r [3];
  logic [63:0] rr_r;
  logic [61:0] or2_r;
  logic [5:0]  ds_r, ls_r;
  logic signed [32:0] dir2_r [3];
  logic [32:0]        mag2_r [3];
  logic signed [31:0] look2_r [3];
  logic [31:0]        lmag2_r [3];
  logic [32:0] dmx, lmx;
  logic [5:0]  ds_nxt, ls_nxt;

  always_comb begin
    dmx = mag_r[0] | mag_r[1] | mag_r[2];
    lmx = 33'(lmag_r[0] | lmag_r[1] | lmag_r[2]);
    ds_nxt = '0;
    ls_nxt = '0;
    // smallest s with (max >> s) < 2^15: index of top bit minus 14
    for (int b = 15; b <= 32; b++) begin
      if (dmx[b]) ds_nxt = 6'(b - 14);
      if (lmx[b]) ls_nxt = 6'(b - 14);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        sq_r[j]    <= 66'(mag_r[j]) * 66'(mag_r[j]);
        dir2_r[j]  <= dir_r[j];
        mag2_r[j]  <= mag_r[j];
        look2_r[j] <= look_r[j];
        lmag2_r[j] <= lmag_r[j];
      end
      rr_r  <= 64'(reach_r) * 64'(reach_r);
      or2_r <= 62'(orad_r) * 62'(orad_r);
      ds_r  <= ds_nxt;
      ls_r  <= ls_nxt;
    end
  end

  // Stage 3: sum, compares, reduced vectors.
  logic [67:0]            s_sum;
  vcv_pkg::vcv_task_t     t_nxt;
  vcv_pkg::vcv_task_t     t_r;
  logic [32:0]            dq [3];
  logic [31:0]            lq [3];

  always_comb begin
    s_sum = 68'(sq_r[0]) + 68'(sq_r[1]) + 68'(sq_r[2]);
    for (int j = 0; j < 3; j++) begin
      dq[j] = mag2_r[j] >> ds_r;
      lq[j] = lmag2_r[j] >> ls_r;
    end
    t_nxt.l0 = look2_r[0][31] ? 16'(-lq[0]) : 16'(lq[0]);
    t_nxt.l1 = look2_r[1][31] ? 16'(-lq[1]) : 16'(lq[1]);
    t_nxt.l2 = look2_r[2][31] ? 16'(-lq[2]) : 16'(lq[2]);
    t_nxt.d0 = dir2_r[0][32] ? 16'(-dq[0]) : 16'(dq[0]);
    t_nxt.d1 = dir2_r[1][32] ? 16'(-dq[1]) : 16'(dq[1]);
    t_nxt.d2 = dir2_r[2][32] ? 16'(-dq[2]) : 16'(dq[2]);
    t_nxt.look_zero = (look2_r[0] | look2_r[1] | look2_r[2]) == 32'sd0;
    priority if (s_sum > 68'(rr_r)) begin
      t_nxt.decided = 1'b1;
      t_nxt.res     = '{visible: 1'b0, reason: vcv_pkg::RSN_OUT_OF_RANGE};
    end else if (s_sum <= 68'(or2_r)) begin
      t_nxt.decided = 1'b1;
      t_nxt.res     = '{visible: 1'b1, reason: vcv_pkg::RSN_OVERLAP};
    end else begin
      t_nxt.decided = 1'b0;
      t_nxt.res     = '{visible: 1'b0, reason: vcv_pkg::RSN_OUT_CONE};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) t_r <= t_nxt;
  end
  assign t_data = t_r;

endmodule

@@ rtl/vcv_queue.sv @@
// Short FIFO between the front and back parts.
module vcv_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                w_valid,
  output logic                w_ready,
  input  vcv_pkg::vcv_task_t  w_data,
  output logic                r_valid,
  input  logic                r_ready,
  output vcv_pkg::vcv_task_t  r_data
);

  vcv_pkg::vcv_task_t            mem_r [vcv_pkg::Q_DEPTH];
  logic [vcv_pkg::Q_AW-1:0]      wp_r, rp_r;
  logic [vcv_pkg::Q_AW:0]        cnt_r;
  logic                          wr, rd;

  assign w_ready = cnt_r != (vcv_pkg::Q_AW+1)'(vcv_pkg::Q_DEPTH);
  assign r_valid = cnt_r != '0;
  assign r_data  = mem_r[rp_r];
  assign wr      = w_valid && w_ready;
  assign rd      = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= w_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (vcv_pkg::Q_AW+1)'(wr) - (vcv_pkg::Q_AW+1)'(rd);
    end
  end

endmodule

@@ rtl/vcv_back.sv @@
// Back part: dot/cross products, integer square root and CORDIC, pipelined.
module vcv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         fov_degrees,
  input  logic                t_valid,
  output logic                t_ready,
  input  vcv_pkg::vcv_task_t  t_data,
  output logic                o_valid,
  input  logic                o_ready,
  output vcv_pkg::vcv_out_t   o_data
);

  localparam int SQ_STEPS = 32;               // isqrt of a 64-bit value
  localparam int NST      = 2 + SQ_STEPS + 1 + vcv_pkg::CORDIC_STEPS + 1;
  localparam int W        = vcv_pkg::CRD_W;
  localparam int AW       = vcv_pkg::ANG_W;

  typedef struct packed {
    logic                  decided;
    vcv_pkg::vcv_out_t     res;
    logic                  look_zero;
    logic signed [32:0]    dot;
    logic [63:0]           rem;   // isqrt remainder
    logic [63:0]           num;   // isqrt operand bits left
    logic [31:0]           root;
    logic signed [W-1:0]   x;
    logic signed [W-1:0]   y;
    logic signed [AW-1:0]  z;
  } stg_t;

  stg_t       s_r [NST];
  stg_t       s_nxt [NST-1];
  stg_t       fin_nxt;
  logic [NST-1:0] v_r;
  logic       adv;

  assign adv     = !v_r[NST-1] || o_ready;
  assign t_ready = adv;
  assign o_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], t_valid};
    end
  end

  // Products of reduced 16-bit components.
  logic signed [31:0] p [9];
  always_comb begin
    p[0] = t_data.l0 * t_data.d0;
    p[1] = t_data.l1 * t_data.d1;
    p[2] = t_data.l2 * t_data.d2;
    p[3] = t_data.l1 * t_data.d2;
    p[4] = t_data.l2 * t_data.d1;
    p[5] = t_data.l2 * t_data.d0;
    p[6] = t_data.l0 * t_data.d2;
    p[7] = t_data.l0 * t_data.d1;
    p[8] = t_data.l1 * t_data.d0;
  end

  logic signed [32:0] c_r [3];
  logic signed [32:0] c_mag [3];
  logic [65:0]        cs;

  always_comb begin
    // stage 0: products into dot and cross components
    s_nxt[0]           = '0;
    s_nxt[0].decided   = t_data.decided;
    s_nxt[0].res       = t_data.res;
    s_nxt[0].look_zero = t_data.look_zero;
    s_nxt[0].dot       = 33'(p[0]) + 33'(p[1]) + 33'(p[2]);
    // stage 1: sum of squared cross components
    for (int j = 0; j < 3; j++) c_mag[j] = c_r[j][32] ? -c_r[j] : c_r[j];
    cs = 66'(c_mag[0]) * 66'(c_mag[0]) + 66'(c_mag[1]) * 66'(c_mag[1])
       + 66'(c_mag[2]) * 66'(c_mag[2]);
    s_nxt[1]     = s_r[0];
    s_nxt[1].num = 64'(cs);
    s_nxt[1].rem = '0;
    s_nxt[1].root = '0;
    // isqrt, one result bit per stage
    for (int k = 0; k < SQ_STEPS; k++) begin
      logic [63:0] r2;
      logic [63:0] trial;
      s_nxt[2+k] = s_r[1+k];
      r2    = {s_r[1+k].rem[61:0], s_r[1+k].num[63:62]};
      trial = {30'd0, s_r[1+k].root, 2'b01};
      s_nxt[2+k].num = {s_r[1+k].num[61:0], 2'b00};
      if (r2 >= trial) begin
        s_nxt[2+k].rem  = r2 - trial;
        s_nxt[2+k].root = {s_r[1+k].root[30:0], 1'b1};
      end else begin
        s_nxt[2+k].rem  = r2;
        s_nxt[2+k].root = {s_r[1+k].root[30:0], 1'b0};
      end
    end
    // CORDIC setup with quadrant fold
    s_nxt[2+SQ_STEPS] = s_r[1+SQ_STEPS];
    if (s_r[1+SQ_STEPS].dot < 0) begin
      s_nxt[2+SQ_STEPS].x = W'({s_r[1+SQ_STEPS].root, 24'd0});
      s_nxt[2+SQ_STEPS].y = W'({-s_r[1+SQ_STEPS].dot, 24'd0});
      s_nxt[2+SQ_STEPS].z = AW'(90 <<< vcv_pkg::FRAC_BITS);
    end else begin
      s_nxt[2+SQ_STEPS].x = W'({s_r[1+SQ_STEPS].dot, 24'd0});
      s_nxt[2+SQ_STEPS].y = W'({s_r[1+SQ_STEPS].root, 24'd0});
      s_nxt[2+SQ_STEPS].z = '0;
    end
    // CORDIC steps
    for (int i = 0; i < vcv_pkg::CORDIC_STEPS; i++) begin
      stg_t a;
      a = s_r[2+SQ_STEPS+i];
      s_nxt[3+SQ_STEPS+i] = a;
      if (!a.y[W-1]) begin
        s_nxt[3+SQ_STEPS+i].x = a.x + (a.y >>> i);
        s_nxt[3+SQ_STEPS+i].y = a.y - (a.x >>> i);
        s_nxt[3+SQ_STEPS+i].z = a.z + vcv_pkg::step_angle(i);
      end else begin
        s_nxt[3+SQ_STEPS+i].x = a.x - (a.y >>> i);
        s_nxt[3+SQ_STEPS+i].y = a.y + (a.x >>> i);
        s_nxt[3+SQ_STEPS+i].z = a.z - vcv_pkg::step_angle(i);
      end
    end
  end

  // Stage registers; cross components live beside stage 0.
  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0] <= 33'(p[3]) - 33'(p[4]);
      c_r[1] <= 33'(p[5]) - 33'(p[6]);
      c_r[2] <= 33'(p[7]) - 33'(p[8]);
      for (int k = 0; k < NST - 1; k++) s_r[k] <= s_nxt[k];
      s_r[NST-1] <= fin_nxt;
    end
  end

  // Final stage: clamp and compare with the field of view.
  stg_t                 fin;
  logic signed [AW-1:0] zc;
  logic signed [AW-1:0] lim;
  always_comb begin
    fin = s_r[NST-2];
    lim = AW'(180 <<< vcv_pkg::FRAC_BITS);
    zc  = fin.z;
    if (zc < 0) zc = '0;
    if (zc > lim) zc = lim;
    fin_nxt = fin;
    if (!fin.decided) begin
      if (!fin.look_zero && (zc < $signed(AW'({fov_degrees, {(vcv_pkg::FRAC_BITS-8){1'b0}}}))))
      begin
        fin_nxt.res = '{visible: 1'b1, reason: vcv_pkg::RSN_IN_CONE};
      end else begin
        fin_nxt.res = '{visible: 1'b0, reason: vcv_pkg::RSN_OUT_CONE};
      end
    end
  end

  assign o_data = s_r[NST-1].res;

endmodule

@@ rtl/view_cone_visibility_test_core.sv @@
// Stages: 3 in the front part and 56 in the back part, with the queue between them.
// Throughput: one transaction per cycle; both parts are fully pipelined and
// stall together only through the valid/ready handshake and the 4-entry queue.
// The back pipeline length is set by the 32-step square root and 20 CORDIC steps.
// Reset (rst_n low, synchronous) empties all stages and the queue and loads
// sight_distance = 6553600 and fov_degrees = 11520.
module view_cone_visibility_test_core (
  input  logic            clk,
  input  logic            rst_n,
  vcv_in_if.sink          in_ch,
  vcv_out_if.source       out_ch,
  vcv_cfg_if.sink         cfg_ch
);

  logic [30:0] sd_r;
  logic [15:0] fov_r;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r  <= vcv_pkg::SD_RESET;
      fov_r <= vcv_pkg::FOV_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        vcv_pkg::REG_SIGHT_DISTANCE: sd_r  <= cfg_ch.wdata[30:0];
        vcv_pkg::REG_FOV_DEGREES:    fov_r <= cfg_ch.wdata[15:0];
        default: ;
      endcase
    end
  end

  logic               f_valid, f_ready, b_valid, b_ready;
  vcv_pkg::vcv_task_t f_data, b_data;

  vcv_front u_front (
    .clk, .rst_n, .sight_distance(sd_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .t_valid(f_valid), .t_ready(f_ready), .t_data(f_data)
  );

  vcv_queue u_queue (
    .clk, .rst_n,
    .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data),
    .r_valid(b_valid), .r_ready(b_ready), .r_data(b_data)
  );

  vcv_back u_back (
    .clk, .rst_n, .fov_degrees(fov_r),
    .t_valid(b_valid), .t_ready(b_ready), .t_data(b_data),
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_data(out_ch.data)
  );

endmodule
